### design/timestamp_read_pair_tracker_defines.svh
// Assertion macros for the timestamp read pair tracker
`ifndef TIMESTAMP_READ_PAIR_TRACKER_DEFINES_SVH
`define TIMESTAMP_READ_PAIR_TRACKER_DEFINES_SVH
// implication checked on every clock unless reset is low
`define TRPT_ASSERT_IMPL(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("assertion failed");
// next-cycle implication
`define TRPT_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("assertion failed");
`endif

### design/trpt_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// trpt_pkg
// Shared types and constants of the timestamp read pair tracker.
// ---------------------------------------------------------------------------
package trpt_pkg;
    localparam logic [1:0] VERDICT_TRACK = 2'd0;
    localparam logic [1:0] VERDICT_DROP  = 2'd1;
    localparam logic [1:0] VERDICT_FOUND = 2'd2;

    localparam logic [1:0] CFG_DIST  = 2'd0;
    localparam logic [1:0] CFG_GAP   = 2'd1;
    localparam logic [1:0] CFG_COUNT = 2'd2;

    localparam logic [12:0] DIST_RESET  = 13'd256;
    localparam logic [31:0] GAP_RESET   = 32'h0005_0000;
    localparam logic [15:0] COUNT_RESET = 16'd255;
    localparam logic [15:0] SKIP_DIVISOR = 16'd20;
    localparam logic [15:0] SYNC_LIMIT  = 16'd2;
    localparam logic [15:0] MAX16 = 16'hFFFF;
endpackage

### design/timestamp_read_pair_tracker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// timestamp_read_pair_tracker
// Pair table of timestamp read sites with gap averaging and verdicts.
// ---------------------------------------------------------------------------
// Flow: after the accepting edge the FSM scans the table one slot per cycle
// through the shared match/age compare, then runs the update, gap, skip-limit
// and judge/output steps before the o_valid strobe; the gap step runs only on
// an after hit, and a zero address gives the strobe straight from idle. Busy
// drops in the strobe cycle, so the next event can be started while o_valid
// is high. The receiver cannot stall: o_valid lasts one cycle.
// Synchronous active-low reset clears the table and loads register defaults.
`include "timestamp_read_pair_tracker_defines.svh"
module timestamp_read_pair_tracker
    import trpt_pkg::*;
#(
    parameter int TABLE_ENTRIES = 8,
    parameter int ADDRESS_BITS  = 48
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [47:0] i_code_address,
    input  logic [63:0] i_time_value,
    input  logic [15:0] i_process_id,
    input  logic [15:0] i_thread_id,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output logic        o_valid,
    output logic [1:0]  o_verdict,
    output logic [5:0]  o_slot_index,
    output logic [47:0] o_first_address,
    output logic [47:0] o_second_address,
    output logic [31:0] o_average_gap,
    output logic [15:0] o_skip_total
);
    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int AW = (ADDRESS_BITS < 48) ? ADDRESS_BITS : 48;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_UPD  = 3'd2;
    localparam logic [2:0] S_GAP  = 3'd3;
    localparam logic [2:0] S_JDG  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [31:0] r_tag  [TABLE_ENTRIES];
    logic [47:0] r_fa   [TABLE_ENTRIES];
    logic [15:0] r_fc   [TABLE_ENTRIES];
    logic [63:0] r_ft   [TABLE_ENTRIES];
    logic [47:0] r_sa   [TABLE_ENTRIES];
    logic [15:0] r_sc   [TABLE_ENTRIES];
    logic [63:0] r_st   [TABLE_ENTRIES];
    logic [31:0] r_avg  [TABLE_ENTRIES];
    logic [15:0] r_skip [TABLE_ENTRIES];

    logic [12:0] r_dist;
    logic [31:0] r_glim;
    logic [15:0] r_cthr;

    logic [2:0]  r_state;
    logic [IW-1:0] r_i;
    logic [47:0] r_addr;
    logic [63:0] r_ts;
    logic [31:0] r_itag;
    logic        r_match, r_free, r_orph, r_pair;
    logic [IW-1:0] r_mi, r_fi, r_oi, r_pi, r_sel;
    logic [63:0] r_gap;
    logic [15:0] r_lim;

    // scan compare on the current slot
    logic [47:0] c_fa, c_sa, c_dist;
    logic        c_used, c_mt;
    always_comb begin
        c_fa = r_fa[r_i];
        c_sa = r_sa[r_i];
        c_dist = (c_fa > r_addr) ? c_fa - r_addr : r_addr - c_fa;
        c_used = (c_fa != '0);
        c_mt = c_used && (r_tag[r_i] == r_itag) && (c_dist < {35'd0, r_dist}) &&
               (c_fa == r_addr || c_sa == r_addr || c_sa == '0);
    end

    // judge inputs on the selected slot
    logic [15:0] j_fc, j_sc, j_diff;
    logic [31:0] j_avg;
    logic [1:0]  j_v;
    always_comb begin
        j_fc = r_fc[r_sel];
        j_sc = r_sc[r_sel];
        j_avg = r_avg[r_sel];
        j_diff = (j_fc > j_sc) ? j_fc - j_sc : j_sc - j_fc;
        if (j_avg == '0 || r_sa[r_sel] == '0) begin
            j_v = VERDICT_TRACK;
        end else if (j_avg > r_glim) begin
            j_v = VERDICT_DROP;
        end else if (j_fc > r_cthr) begin
            j_v = (j_diff < SYNC_LIMIT && r_skip[r_sel] < r_lim) ? VERDICT_FOUND
                                                                : VERDICT_DROP;
        end else begin
            j_v = VERDICT_TRACK;
        end
    end

    logic [31:0] g_d, g_avg;
    logic [33:0] g_half;
    always_comb begin
        g_d = (r_gap[63:32] != '0) ? 32'hFFFF_FFFF : r_gap[31:0];
        g_avg = r_avg[r_sel];
        g_half = ({2'b0, g_avg} * 34'd3) >> 1;
    end

    // count / 20 as (count / 4) * ceil(2^18 / 5) >> 18, exact for 14-bit values
    logic [31:0] l_prod;
    assign l_prod = {18'd0, r_fc[r_sel][15:2]} * 32'd52429;

    assign busy = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE) && !start;

    logic [IW-1:0] last_i;
    assign last_i = IW'(TABLE_ENTRIES - 1);

    always_ff @(posedge i_clk) begin
        o_valid <= 1'b0;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_dist <= DIST_RESET;
            r_glim <= GAP_RESET;
            r_cthr <= COUNT_RESET;
            for (int k = 0; k < TABLE_ENTRIES; k++) begin
                r_tag[k] <= '0; r_fa[k] <= '0; r_fc[k] <= '0; r_ft[k] <= '0;
                r_sa[k] <= '0; r_sc[k] <= '0; r_st[k] <= '0; r_avg[k] <= '0;
                r_skip[k] <= '0;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_cfg_valid && o_cfg_ready) begin
                        case (i_cfg_index)
                            CFG_DIST:  r_dist <= i_cfg_data[12:0];
                            CFG_GAP:   r_glim <= i_cfg_data;
                            CFG_COUNT: r_cthr <= i_cfg_data[15:0];
                            default: ;
                        endcase
                    end
                    if (start) begin
                        r_addr <= {48'(i_code_address[AW-1:0])};
                        r_ts <= i_time_value;
                        r_itag <= {i_process_id, i_thread_id};
                        r_i <= '0;
                        r_match <= 1'b0; r_free <= 1'b0;
                        r_orph <= 1'b0; r_pair <= 1'b0;
                        if ({48'(i_code_address[AW-1:0])} == '0) begin
                            o_valid <= 1'b1;
                            o_verdict <= VERDICT_TRACK;
                            o_slot_index <= '0;
                            o_first_address <= '0;
                            o_second_address <= '0;
                            o_average_gap <= '0;
                            o_skip_total <= '0;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (c_mt && !r_match) begin
                        r_match <= 1'b1; r_mi <= r_i;
                    end
                    if (!c_used) begin
                        if (!r_free) begin
                            r_free <= 1'b1; r_fi <= r_i;
                        end
                    end else if (c_sa == '0) begin
                        if (!r_orph || r_ft[r_i] < r_ft[r_oi]) begin
                            r_orph <= 1'b1; r_oi <= r_i;
                        end
                    end else begin
                        if (!r_pair || r_ft[r_i] < r_ft[r_pi]) begin
                            r_pair <= 1'b1; r_pi <= r_i;
                        end
                    end
                    if (r_i == last_i) r_state <= S_UPD;
                    else r_i <= r_i + 1'b1;
                end
                S_UPD: begin
                    r_state <= S_JDG;
                    if (r_match) begin
                        r_sel <= r_mi;
                        if (r_fa[r_mi] == r_addr) begin
                            r_fc[r_mi] <= (r_fc[r_mi] == MAX16) ? MAX16 : r_fc[r_mi] + 1'b1;
                            r_ft[r_mi] <= r_ts;
                        end else if (r_sa[r_mi] == r_addr || r_fa[r_mi] < r_addr) begin
                            r_sa[r_mi] <= r_addr;
                            r_gap <= (r_ts > r_ft[r_mi]) ? r_ts - r_ft[r_mi]
                                                         : r_ft[r_mi] - r_ts;
                            r_sc[r_mi] <= (r_sc[r_mi] == MAX16) ? MAX16 : r_sc[r_mi] + 1'b1;
                            r_st[r_mi] <= r_ts;
                            r_state <= S_GAP;
                        end else begin
                            r_sa[r_mi] <= r_fa[r_mi];
                            r_sc[r_mi] <= r_fc[r_mi];
                            r_st[r_mi] <= r_ft[r_mi];
                            r_fa[r_mi] <= r_addr;
                            r_fc[r_mi] <= 16'd1;
                            r_ft[r_mi] <= r_ts;
                        end
                    end else begin
                        r_sel <= r_free ? r_fi : (r_orph ? r_oi : r_pi);
                        for (int k = 0; k < TABLE_ENTRIES; k++) begin
                            if (IW'(k) == (r_free ? r_fi : (r_orph ? r_oi : r_pi))) begin
                                r_tag[k] <= r_itag; r_fa[k] <= r_addr; r_fc[k] <= 16'd1;
                                r_ft[k] <= r_ts; r_sa[k] <= '0; r_sc[k] <= '0;
                                r_st[k] <= '0; r_avg[k] <= '0; r_skip[k] <= '0;
                            end
                        end
                    end
                end
                S_GAP: begin
                    if (g_avg == '0) begin
                        r_avg[r_sel] <= g_d;
                    end else if (g_d > g_avg && {2'b0, g_d - g_avg} > g_half) begin
                        r_skip[r_sel] <= (r_skip[r_sel] == MAX16) ? MAX16
                                                                  : r_skip[r_sel] + 1'b1;
                    end else begin
                        r_avg[r_sel] <= 32'(({1'b0, g_avg} + {1'b0, g_d}) >> 1);
                    end
                    r_state <= S_JDG;
                end
                S_JDG: begin
                    // skip limit: max(first_count / 20, 1)
                    r_lim <= (r_fc[r_sel] < SKIP_DIVISOR) ? 16'd1 : {2'b0, l_prod[31:18]};
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    o_valid <= 1'b1;
                    o_verdict <= j_v;
                    o_slot_index <= 6'(r_sel);
                    o_first_address <= r_fa[r_sel];
                    o_second_address <= r_sa[r_sel];
                    o_average_gap <= r_avg[r_sel];
                    o_skip_total <= r_skip[r_sel];
                    if (j_v != VERDICT_TRACK) begin
                        r_tag[r_sel] <= '0; r_fa[r_sel] <= '0; r_fc[r_sel] <= '0;
                        r_ft[r_sel] <= '0; r_sa[r_sel] <= '0; r_sc[r_sel] <= '0;
                        r_st[r_sel] <= '0; r_avg[r_sel] <= '0; r_skip[r_sel] <= '0;
                    end
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `TRPT_ASSERT_IMPL(a_out_idle, i_clk, i_rst_n, o_valid, r_state == S_IDLE)
    `TRPT_ASSERT_NEXT(a_busy_out, i_clk, i_rst_n, r_state == S_OUT, o_valid && !busy)
    `TRPT_ASSERT_IMPL(a_verdict_ok, i_clk, i_rst_n, o_valid, o_verdict <= VERDICT_FOUND)
endmodule
